// ----- rtl/core/iee_pkg.sv -----
// Package for the integer expression evaluator.
// Holds the operator, scan phase, mode and status codes and the small helper functions.
// No dependencies.
package iee_pkg;

	typedef enum logic [3:0] {
		PH_OPERAND  = 4'd0,
		PH_ZERO     = 4'd1,
		PH_DEC      = 4'd2,
		PH_HEX      = 4'd3,
		PH_OCT      = 4'd4,
		PH_BIN      = 4'd5,
		PH_OPERATOR = 4'd6,
		PH_LT       = 4'd7,
		PH_GT       = 4'd8,
		PH_DONE     = 4'd9
	} phase_t;

	typedef logic [3:0] op_t;

	localparam op_t OP_OR        = 4'd0;
	localparam op_t OP_XOR       = 4'd1;
	localparam op_t OP_AND       = 4'd2;
	localparam op_t OP_SHL       = 4'd3;
	localparam op_t OP_SHR       = 4'd4;
	localparam op_t OP_ADD       = 4'd5;
	localparam op_t OP_SUB       = 4'd6;
	localparam op_t OP_MUL       = 4'd7;
	localparam op_t OP_DIV       = 4'd8;
	localparam op_t OP_MOD       = 4'd9;
	localparam op_t OP_PAREN     = 4'd10;
	localparam op_t OP_PAREN_NEG = 4'd11;

	typedef enum logic [1:0] {
		MD_BINOP = 2'd0,
		MD_CLOSE = 2'd1,
		MD_PAREN = 2'd2,
		MD_FINAL = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_BINOP = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_PAREN = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [1:0] ST_MOD_ZERO = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [4:0] RADIX_HEX = 5'd16;
	localparam logic [4:0] RADIX_OCT = 5'd8;
	localparam logic [4:0] RADIX_DEC = 5'd10;
	localparam logic [4:0] RADIX_BIN = 5'd2;
	localparam logic [4:0] NO_DIGIT  = 5'd31;

	function automatic logic [2:0] op_level(op_t op);
		logic [2:0] l;
		unique case (op)
			OP_OR:           l = 3'd1;
			OP_XOR:          l = 3'd2;
			OP_AND:          l = 3'd3;
			OP_SHL, OP_SHR:  l = 3'd4;
			OP_ADD, OP_SUB:  l = 3'd5;
			default:         l = 3'd6;
		endcase
		return l;
	endfunction

	function automatic logic [4:0] digit_of(logic [7:0] c, logic [4:0] radix);
		logic [4:0] d;
		d = NO_DIGIT;
		if (c >= "0" && c <= "9")
			d = 5'(c - "0");
		else if (radix == RADIX_HEX && c >= "a" && c <= "f")
			d = 5'(c - "a" + 8'd10);
		else if (radix == RADIX_HEX && c >= "A" && c <= "F")
			d = 5'(c - "A" + 8'd10);
		return (d < radix) ? d : NO_DIGIT;
	endfunction

endpackage

// ----- rtl/core/integer_expression_evaluator_top.sv -----
// Integer expression evaluator: one character per item in, one value and status per line out.
// Pending operands and operators live in a synchronous stack memory; mul and div are iterative.
// Depends on iee_pkg.
//
// Usage: the char channel (char_valid, char_stall, char_code, last_char) takes one ASCII
// character per item. The item with last_char set closes the line and produces one result
// item (result_value, status) on the result channel (result_valid, result_stall).
// An operator or parenthesis that reduces the stack pops each level with a memory read,
// then an evaluate; each multiply, divide or remainder is then worked out bit by bit on
// one shared shift unit. The last character then reduces every level left on the stack.
// The result is held in an output register; while the receiver stalls it stays unchanged
// and the evaluator can take the next line's characters until that line's end needs it.
// Reset clears the stack pointer, scan state and output valid; the stack memory itself
// is not cleared, as entries above the pointer are never read.
module integer_expression_evaluator_top #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_BITS  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	output logic              result_valid,
	input  logic              result_stall,
	output logic signed [63:0] result_value,
	output logic [1:0]        status
);
	import iee_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SHW = $clog2(VALUE_BITS);
	localparam int CW  = $clog2(VALUE_BITS + 1);
	localparam int VB  = VALUE_BITS;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_EVAL = 6'b000100,
		S_ITER = 6'b001000,
		S_PUSH = 6'b010000,
		S_FIN  = 6'b100000
	} seq_t;

	logic          out_busy;
	seq_t          state_q;
	mode_t         mode_q;
	op_t           op_q;
	logic          last_q;
	logic [SPW-1:0] sp_q;
	logic [VB-1:0] acc_q, off_q;
	logic          neg_q;
	phase_t        phase_q;
	logic [1:0]    err_q;
	logic          res_pend_q;

	logic [VB-1:0] mem_val [STACK_DEPTH];
	op_t           mem_op  [STACK_DEPTH];
	logic [VB-1:0] rd_val_q;
	op_t           rd_op_q;

	op_t           it_op_q;
	logic          it_ln_q, it_rn_q;
	logic [VB-1:0] it_a_q, it_b_q, it_r_q;
	logic [CW-1:0] it_cnt_q;

	logic          out_valid_q;
	logic [VB-1:0] out_val_q;
	logic [1:0]    out_st_q;

	logic [AW-1:0] top_addr;
	logic [AW-1:0] push_addr;

	assign top_addr  = AW'(sp_q - SPW'(1));
	assign push_addr = AW'(sp_q);
	assign char_stall = (state_q != S_IDLE) || res_pend_q;
	assign out_busy   = out_valid_q && result_stall;

	assign result_valid = out_valid_q;
	assign result_value = 64'($signed(out_val_q));
	assign status       = out_st_q;

	function automatic logic [VB-1:0] scale(logic [VB-1:0] a, logic [4:0] radix,
		logic [4:0] d);
		logic [VB-1:0] r;
		unique case (radix)
			RADIX_HEX: r = a << 4;
			RADIX_OCT: r = a << 3;
			RADIX_BIN: r = a << 1;
			default:   r = (a << 3) + (a << 1);
		endcase
		return r + VB'(d);
	endfunction

	// Character decode.
	phase_t        dc_phase;
	logic [VB-1:0] dc_acc, dc_off;
	logic          dc_neg;
	cmd_t          dc_cmd;
	op_t           dc_op;

	always_comb begin
		logic          fin, oper;
		logic [4:0]    radix, d;
		dc_phase = phase_q;
		dc_acc   = acc_q;
		dc_off   = off_q;
		dc_neg   = neg_q;
		dc_cmd   = CMD_NONE;
		dc_op    = OP_OR;
		fin      = 1'b0;
		oper     = 1'b0;
		radix    = RADIX_DEC;
		unique case (phase_q)
			PH_HEX:  radix = RADIX_HEX;
			PH_OCT:  radix = RADIX_OCT;
			PH_BIN:  radix = RADIX_BIN;
			default: radix = RADIX_DEC;
		endcase
		d = digit_of(char_code, radix);
		unique case (phase_q)
			PH_OPERAND: begin
				if (char_code == " " || char_code == 8'h09 || char_code == "+") begin
				end else if (char_code == "-") begin
					dc_neg = !neg_q;
				end else if (char_code == "~") begin
					dc_off = neg_q ? off_q + VB'(1) : off_q - VB'(1);
					dc_neg = !neg_q;
				end else if (char_code == "(") begin
					dc_cmd = CMD_PAREN;
					dc_op  = neg_q ? OP_PAREN_NEG : OP_PAREN;
				end else if (char_code == "0") begin
					dc_acc   = '0;
					dc_phase = PH_ZERO;
				end else if (char_code >= "1" && char_code <= "9") begin
					dc_acc   = VB'(char_code - "0");
					dc_phase = PH_DEC;
				end else begin
					dc_acc = '0;
					fin    = 1'b1;
					oper   = 1'b1;
				end
			end
			PH_ZERO: begin
				if (char_code == "x" || char_code == "X") dc_phase = PH_HEX;
				else if (char_code == "b" || char_code == "B") dc_phase = PH_BIN;
				else if (char_code == "o" || char_code == "O") dc_phase = PH_OCT;
				else begin
					dc_phase = PH_DEC;
					if (d != NO_DIGIT) dc_acc = scale(acc_q, RADIX_DEC, d);
					else begin
						fin  = 1'b1;
						oper = 1'b1;
					end
				end
			end
			PH_DEC, PH_HEX, PH_OCT, PH_BIN: begin
				if (d != NO_DIGIT) dc_acc = scale(acc_q, radix, d);
				else begin
					fin  = 1'b1;
					oper = 1'b1;
				end
			end
			PH_OPERATOR: oper = 1'b1;
			PH_LT: begin
				if (char_code == "<") begin
					dc_cmd = CMD_BINOP;
					dc_op  = OP_SHL;
				end else dc_phase = PH_DONE;
			end
			PH_GT: begin
				if (char_code == ">") begin
					dc_cmd = CMD_BINOP;
					dc_op  = OP_SHR;
				end else dc_phase = PH_DONE;
			end
			default: begin
			end
		endcase
		if (fin) begin
			dc_acc   = (neg_q ? VB'(0) - dc_acc : dc_acc) + dc_off;
			dc_neg   = 1'b0;
			dc_off   = '0;
			dc_phase = PH_OPERATOR;
		end
		if (oper) begin
			dc_cmd = CMD_BINOP;
			unique case (char_code)
				"|": dc_op = OP_OR;
				"^": dc_op = OP_XOR;
				"&": dc_op = OP_AND;
				"+": dc_op = OP_ADD;
				"-": dc_op = OP_SUB;
				"*": dc_op = OP_MUL;
				"/": dc_op = OP_DIV;
				"%": dc_op = OP_MOD;
				default: begin
					dc_cmd = CMD_NONE;
					if (char_code == "<") dc_phase = PH_LT;
					else if (char_code == ">") dc_phase = PH_GT;
					else if (char_code == ")") dc_cmd = CMD_CLOSE;
					else if (char_code != " " && char_code != 8'h09) dc_phase = PH_DONE;
				end
			endcase
		end
	end

	// Combinational part of a reduction: left operand from the stack, right is acc.
	logic [VB-1:0] alu_res;
	logic          shift_out;
	logic [SHW-1:0] sh_amt;
	logic          reduce_ok;

	assign shift_out = acc_q[VB-1] || (acc_q >= VB'(VALUE_BITS));
	assign sh_amt    = acc_q[SHW-1:0];

	always_comb begin
		unique case (rd_op_q)
			OP_OR:  alu_res = rd_val_q | acc_q;
			OP_XOR: alu_res = rd_val_q ^ acc_q;
			OP_AND: alu_res = rd_val_q & acc_q;
			OP_SHL: alu_res = shift_out ? '0 : rd_val_q << sh_amt;
			OP_SHR: alu_res = shift_out ? {VB{rd_val_q[VB-1]}}
				: VB'($signed(rd_val_q) >>> sh_amt);
			OP_ADD: alu_res = rd_val_q + acc_q;
			OP_SUB: alu_res = rd_val_q - acc_q;
			OP_PAREN_NEG: alu_res = (VB'(0) - acc_q) + rd_val_q;
			default: alu_res = acc_q + rd_val_q;
		endcase
	end

	always_comb begin
		unique case (mode_q)
			MD_BINOP: reduce_ok = (rd_op_q < OP_PAREN)
				&& (op_level(rd_op_q) >= op_level(op_q));
			default:  reduce_ok = 1'b1;
		endcase
	end

	logic [VB-1:0] rem_sh, it_res;
	assign rem_sh = {it_r_q[VB-2:0], it_a_q[VB-1]};
	always_comb begin
		unique case (it_op_q)
			OP_MUL:  it_res = it_r_q;
			OP_DIV:  it_res = (it_ln_q != it_rn_q) ? VB'(0) - it_a_q : it_a_q;
			default: it_res = it_ln_q ? VB'(0) - it_r_q : it_r_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ && sp_q != '0) begin
			rd_val_q <= mem_val[top_addr];
			rd_op_q  <= mem_op[top_addr];
		end
		if (state_q == S_PUSH && sp_q < SPW'(STACK_DEPTH)) begin
			mem_val[push_addr] <= (mode_q == MD_PAREN) ? off_q : acc_q;
			mem_op[push_addr]  <= op_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MD_BINOP;
			op_q        <= OP_OR;
			last_q      <= 1'b0;
			sp_q        <= '0;
			acc_q       <= '0;
			off_q       <= '0;
			neg_q       <= 1'b0;
			phase_q     <= PH_OPERAND;
			err_q       <= ST_OK;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
			it_cnt_q    <= '0;
		end else begin
			if (res_pend_q && !out_busy) begin
				out_valid_q <= 1'b1;
				out_val_q   <= (err_q != ST_OK) ? '0 : acc_q;
				out_st_q    <= err_q;
				res_pend_q  <= 1'b0;
				sp_q        <= '0;
				acc_q       <= '0;
				off_q       <= '0;
				neg_q       <= 1'b0;
				phase_q     <= PH_OPERAND;
				err_q       <= ST_OK;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (char_valid && !char_stall) begin
						phase_q <= dc_phase;
						acc_q   <= dc_acc;
						off_q   <= dc_off;
						neg_q   <= dc_neg;
						op_q    <= dc_op;
						last_q  <= last_char;
						unique case (dc_cmd)
							CMD_BINOP: begin
								mode_q  <= MD_BINOP;
								state_q <= S_READ;
							end
							CMD_CLOSE: begin
								mode_q  <= MD_CLOSE;
								state_q <= S_READ;
							end
							CMD_PAREN: begin
								mode_q  <= MD_PAREN;
								state_q <= S_PUSH;
							end
							default: state_q <= last_char ? S_FIN : S_IDLE;
						endcase
					end
				end
				S_READ: begin
					if (err_q != ST_OK || sp_q == '0) begin
						unique case (mode_q)
							MD_BINOP: state_q <= (err_q != ST_OK) ?
								(last_q ? S_FIN : S_IDLE) : S_PUSH;
							MD_FINAL: begin
								res_pend_q <= 1'b1;
								state_q    <= S_IDLE;
							end
							default: begin
								if (err_q == ST_OK) phase_q <= PH_DONE;
								state_q <= last_q ? S_FIN : S_IDLE;
							end
						endcase
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!reduce_ok) begin
						state_q <= S_PUSH;
					end else if (rd_op_q >= OP_PAREN) begin
						acc_q <= alu_res;
						sp_q  <= sp_q - SPW'(1);
						state_q <= (mode_q == MD_CLOSE) ? (last_q ? S_FIN : S_IDLE) : S_READ;
					end else if (rd_op_q == OP_MUL) begin
						it_op_q  <= rd_op_q;
						it_a_q   <= rd_val_q;
						it_b_q   <= acc_q;
						it_r_q   <= '0;
						it_cnt_q <= '0;
						state_q  <= S_ITER;
					end else if (rd_op_q == OP_DIV || rd_op_q == OP_MOD) begin
						if (acc_q == '0) begin
							err_q   <= (rd_op_q == OP_DIV) ? ST_DIV_ZERO : ST_MOD_ZERO;
							phase_q <= PH_DONE;
							sp_q    <= sp_q - SPW'(1);
							state_q <= S_READ;
						end else begin
							it_op_q  <= rd_op_q;
							it_ln_q  <= rd_val_q[VB-1];
							it_rn_q  <= acc_q[VB-1];
							it_a_q   <= rd_val_q[VB-1] ? VB'(0) - rd_val_q : rd_val_q;
							it_b_q   <= acc_q[VB-1] ? VB'(0) - acc_q : acc_q;
							it_r_q   <= '0;
							it_cnt_q <= '0;
							state_q  <= S_ITER;
						end
					end else begin
						acc_q   <= alu_res;
						sp_q    <= sp_q - SPW'(1);
						state_q <= S_READ;
					end
				end
				S_ITER: begin
					if (it_cnt_q == CW'(VALUE_BITS)) begin
						acc_q   <= it_res;
						sp_q    <= sp_q - SPW'(1);
						state_q <= S_READ;
					end else begin
						it_cnt_q <= it_cnt_q + CW'(1);
						if (it_op_q == OP_MUL) begin
							if (it_b_q[0]) it_r_q <= it_r_q + it_a_q;
							it_a_q <= it_a_q << 1;
							it_b_q <= it_b_q >> 1;
						end else if (rem_sh >= it_b_q) begin
							it_r_q <= rem_sh - it_b_q;
							it_a_q <= {it_a_q[VB-2:0], 1'b1};
						end else begin
							it_r_q <= rem_sh;
							it_a_q <= {it_a_q[VB-2:0], 1'b0};
						end
					end
				end
				S_PUSH: begin
					if (sp_q >= SPW'(STACK_DEPTH)) begin
						err_q   <= ST_OVERFLOW;
						phase_q <= PH_DONE;
					end else begin
						sp_q <= sp_q + SPW'(1);
						if (mode_q == MD_PAREN) begin
							neg_q <= 1'b0;
							off_q <= '0;
						end else begin
							acc_q   <= '0;
							phase_q <= PH_OPERAND;
						end
					end
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (err_q == ST_OK) begin
						if (phase_q == PH_OPERAND) begin
							acc_q   <= off_q;
							neg_q   <= 1'b0;
							off_q   <= '0;
							phase_q <= PH_OPERATOR;
						end else if (phase_q >= PH_ZERO && phase_q <= PH_BIN) begin
							acc_q   <= (neg_q ? VB'(0) - acc_q : acc_q) + off_q;
							neg_q   <= 1'b0;
							off_q   <= '0;
							phase_q <= PH_OPERATOR;
						end
						mode_q  <= MD_FINAL;
						state_q <= S_READ;
					end else begin
						res_pend_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/iee_checker.sv -----
// Port-level checker for the integer expression evaluator, with its bind statement.
// Watches the char and result channels of integer_expression_evaluator_top only.
// Depends on iee_pkg.
module iee_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              char_valid,
	input logic              char_stall,
	input logic              last_char,
	input logic              result_valid,
	input logic              result_stall,
	input logic signed [63:0] result_value,
	input logic [1:0]        status
);
	import iee_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_value) && $stable(status))
		else $error("stalled result item changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> result_value == 64'sd0)
		else $error("error result carries a non-zero value");

	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && last_char |=> char_stall)
		else $error("line end did not hold off the next item");

endmodule

bind integer_expression_evaluator_top iee_checker u_iee_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.char_valid   (char_valid),
	.char_stall   (char_stall),
	.last_char    (last_char),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_value (result_value),
	.status       (status)
);
